// ===== rtl/transposition_table_probe_store_macros.svh =====
// assertion macros used by the transposition table port checker
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_MACROS_SVH

// same-cycle implication, idle while reset is high
`define TTPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ttps assertion failed");

// next-cycle implication, idle while reset is high
`define TTPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ttps assertion failed");

`endif

// ===== rtl/ttps_pkg.sv =====
// shared types, widths and constants of the transposition table
package ttps_pkg;

  // field widths
  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 17;
  localparam int KIND_W  = 2;
  localparam int MOVE_W  = 24;
  localparam int PLY_W   = 8;
  localparam int WIDE_W  = SCORE_W + 1;

  // default table size
  localparam int ENTRIES_DEFAULT = 65536;

  // score limits, held one bit wider than a score
  localparam logic signed [WIDE_W-1:0] MATE_LIMIT = 18'sd48000;
  localparam logic signed [WIDE_W-1:0] SCORE_MAX  = 18'sd65535;
  localparam logic signed [WIDE_W-1:0] SCORE_MIN  = -18'sd65535;

  // operation codes
  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // bound kinds
  localparam logic [KIND_W-1:0] BOUND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] BOUND_EXACT = 2'd1;
  localparam logic [KIND_W-1:0] BOUND_UPPER = 2'd2;
  localparam logic [KIND_W-1:0] BOUND_LOWER = 2'd3;

  // one table slot
  typedef struct packed {
    logic        [KEY_W-1:0]   key;
    logic        [DEPTH_W-1:0] depth;
    logic        [KIND_W-1:0]  kind;
    logic signed [SCORE_W-1:0] score;
    logic        [MOVE_W-1:0]  move;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic take;
    logic eval;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } status_t;

endpackage

// ===== rtl/transposition_table_probe_store.sv =====
// A store is taken without leaving idle, so the next word may follow in the
// next cycle. A probe reads its slot over the slot memory's registered read,
// is evaluated in the EVAL state and shows its result in the HOLD state; the
// next word is taken in the cycle after that result is accepted.
// After reset a clearing pass writes one slot per cycle, from slot 0 up to
// slot ENTRIES-1, with in_stall high; every slot then reads as all zero.
module transposition_table_probe_store #(
  parameter int ENTRIES = ttps_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic        [ttps_pkg::KEY_W-1:0]   key,
  input  logic        [ttps_pkg::DEPTH_W-1:0] depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
  input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
  input  logic        [ttps_pkg::KIND_W-1:0]  bound_kind,
  input  logic signed [ttps_pkg::SCORE_W-1:0] score,
  input  logic        [ttps_pkg::MOVE_W-1:0]  move_in,
  input  logic        [ttps_pkg::PLY_W-1:0]   ply,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                key_matched,
  output logic        [ttps_pkg::MOVE_W-1:0]  hint_move,
  output logic                                score_valid,
  output logic signed [ttps_pkg::SCORE_W-1:0] answer_score
);
  import ttps_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  ttps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // table and evaluation
  ttps_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .key          (key),
    .depth        (depth),
    .alpha        (alpha),
    .beta         (beta),
    .bound_kind   (bound_kind),
    .score        (score),
    .move_in      (move_in),
    .ply          (ply),
    .key_matched  (key_matched),
    .hint_move    (hint_move),
    .score_valid  (score_valid),
    .answer_score (answer_score)
  );

endmodule

// ===== rtl/ttps_ctrl.sv =====
// sequencer for clearing, accepting, evaluating and handing off words
module ttps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  input  logic             out_stall,
  input  ttps_pkg::status_t status,
  output logic             in_stall,
  output logic             out_valid,
  output ttps_pkg::cmd_t   cmd
);
  import ttps_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign take      = in_valid && (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_HOLD);

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.clear_en = (state == ST_CLEAR);
    cmd.take     = take;
    cmd.eval     = (state == ST_EVAL);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take && (operation == OP_PROBE)) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ttps_datapath.sv =====
// slot memory, mate score adjustment and probe evaluation
module ttps_datapath #(
  parameter int ENTRIES = ttps_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ttps_pkg::cmd_t                      cmd,
  output ttps_pkg::status_t                   status,
  input  logic                                operation,
  input  logic        [ttps_pkg::KEY_W-1:0]   key,
  input  logic        [ttps_pkg::DEPTH_W-1:0] depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
  input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
  input  logic        [ttps_pkg::KIND_W-1:0]  bound_kind,
  input  logic signed [ttps_pkg::SCORE_W-1:0] score,
  input  logic        [ttps_pkg::MOVE_W-1:0]  move_in,
  input  logic        [ttps_pkg::PLY_W-1:0]   ply,
  output logic                                key_matched,
  output logic        [ttps_pkg::MOVE_W-1:0]  hint_move,
  output logic                                score_valid,
  output logic signed [ttps_pkg::SCORE_W-1:0] answer_score
);
  import ttps_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  entry_t                     mem [ENTRIES];
  entry_t                     rd_q;
  entry_t                     st_entry;
  logic        [IDX_W-1:0]    clr_addr;
  logic        [IDX_W-1:0]    idx;
  logic signed [WIDE_W-1:0]   st_wide;
  logic signed [WIDE_W-1:0]   st_adj;
  logic signed [WIDE_W-1:0]   st_sat;

  logic        [KEY_W-1:0]    probe_key;
  logic        [DEPTH_W-1:0]  probe_depth;
  logic signed [SCORE_W-1:0]  probe_alpha;
  logic signed [SCORE_W-1:0]  probe_beta;
  logic        [PLY_W-1:0]    probe_ply;

  logic                       hit;
  logic                       deep;
  logic signed [WIDE_W-1:0]   ld_wide;
  logic signed [WIDE_W-1:0]   ld_adj;
  logic signed [WIDE_W-1:0]   alpha_wide;
  logic signed [WIDE_W-1:0]   beta_wide;
  logic                       ans_valid;
  logic signed [SCORE_W-1:0]  ans;

  assign idx = key[IDX_W-1:0];

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_last = (clr_addr == IDX_W'(ENTRIES - 1));

  // push mate scores away from zero, then saturate
  always_comb begin
    st_wide = WIDE_W'(score);
    if (st_wide > MATE_LIMIT) begin
      st_adj = st_wide + $signed(WIDE_W'(ply));
    end else if (st_wide < -MATE_LIMIT) begin
      st_adj = st_wide - $signed(WIDE_W'(ply));
    end else begin
      st_adj = st_wide;
    end
    if (st_adj > SCORE_MAX) begin
      st_sat = SCORE_MAX;
    end else if (st_adj < SCORE_MIN) begin
      st_sat = SCORE_MIN;
    end else begin
      st_sat = st_adj;
    end
    st_entry.key   = key;
    st_entry.depth = depth;
    st_entry.kind  = bound_kind;
    st_entry.score = st_sat[SCORE_W-1:0];
    st_entry.move  = move_in;
  end

  // slot memory: single port, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.take && (operation == OP_STORE)) begin
      mem[idx] <= st_entry;
    end
    if (cmd.take) begin
      rd_q <= mem[idx];
    end
  end

  // hold the probe fields for evaluation
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      probe_key   <= key;
      probe_depth <= depth;
      probe_alpha <= alpha;
      probe_beta  <= beta;
      probe_ply   <= ply;
    end
  end

  // probe evaluation on the read slot
  always_comb begin
    hit        = (rd_q.key == probe_key);
    deep       = (rd_q.depth >= probe_depth);
    ld_wide    = WIDE_W'($signed(rd_q.score));
    alpha_wide = WIDE_W'(probe_alpha);
    beta_wide  = WIDE_W'(probe_beta);
    if (ld_wide > MATE_LIMIT) begin
      ld_adj = ld_wide - $signed(WIDE_W'(probe_ply));
    end else if (ld_wide < -MATE_LIMIT) begin
      ld_adj = ld_wide + $signed(WIDE_W'(probe_ply));
    end else begin
      ld_adj = ld_wide;
    end
    ans_valid = 1'b0;
    ans       = '0;
    if (hit && deep) begin
      case (rd_q.kind)
        BOUND_EXACT: begin
          ans_valid = 1'b1;
          ans       = ld_adj[SCORE_W-1:0];
        end
        BOUND_UPPER: begin
          if (ld_adj <= alpha_wide) begin
            ans_valid = 1'b1;
            ans       = probe_alpha;
          end
        end
        BOUND_LOWER: begin
          if (ld_adj >= beta_wide) begin
            ans_valid = 1'b1;
            ans       = probe_beta;
          end
        end
        default: begin
          ans_valid = 1'b0;
        end
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      key_matched  <= hit;
      hint_move    <= hit ? rd_q.move : '0;
      score_valid  <= ans_valid;
      answer_score <= ans;
    end
  end

endmodule

// ===== rtl/ttps_checker.sv =====
// port-level checks of the transposition table, bound to the top level
`include "transposition_table_probe_store_macros.svh"

module ttps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                operation,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                key_matched,
  input logic        [ttps_pkg::MOVE_W-1:0]  hint_move,
  input logic                                score_valid,
  input logic signed [ttps_pkg::SCORE_W-1:0] answer_score
);
  import ttps_pkg::*;

  // a stalled result word holds
  `TTPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(answer_score) && $stable(hint_move))

  // a missed key carries no move and no score
  `TTPS_ASSERT_NOW(a_miss_empty, out_valid && !key_matched, hint_move == '0 && !score_valid)

  // an unknown score reads as zero
  `TTPS_ASSERT_NOW(a_unknown_zero, out_valid && !score_valid, answer_score == '0)

  // no word is taken while a result waits
  `TTPS_ASSERT_NOW(a_one_in_flight, out_valid, in_stall)

  // a taken probe is still being evaluated in the next cycle
  `TTPS_ASSERT_NEXT(a_probe_eval, in_valid && !in_stall && operation == OP_PROBE, in_stall && !out_valid)

endmodule

bind transposition_table_probe_store ttps_checker u_ttps_checker (.*);

// ===== dv/transposition_table_probe_store_checker.sv =====
`timescale 1ns / 1ps
// channel monitor and answer predictor for the transposition table
module transposition_table_probe_store_checker #(
  parameter int ENTRIES = ttps_pkg::ENTRIES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                operation,
  input  logic        [ttps_pkg::KEY_W-1:0]   key,
  input  logic        [ttps_pkg::DEPTH_W-1:0] depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
  input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
  input  logic        [ttps_pkg::KIND_W-1:0]  bound_kind,
  input  logic signed [ttps_pkg::SCORE_W-1:0] score,
  input  logic        [ttps_pkg::MOVE_W-1:0]  move_in,
  input  logic        [ttps_pkg::PLY_W-1:0]   ply,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                key_matched,
  input  logic        [ttps_pkg::MOVE_W-1:0]  hint_move,
  input  logic                                score_valid,
  input  logic signed [ttps_pkg::SCORE_W-1:0] answer_score,
  output int                                  mismatches,
  output int                                  pending
);
  import ttps_pkg::*;

  localparam int MATE    = int'(MATE_LIMIT);
  localparam int TOP_CAP = int'(SCORE_MAX);
  localparam int BOT_CAP = int'(SCORE_MIN);

  typedef struct packed {
    logic                      matched;
    logic        [MOVE_W-1:0]  move;
    logic                      scored;
    logic signed [SCORE_W-1:0] value;
  } probe_answer_t;

  // shadow copy of the slots; a slot never written reads as cleared
  entry_t        slot_store [int];
  probe_answer_t answers_due [$];
  probe_answer_t want;

  function automatic int slot_index(logic [KEY_W-1:0] k);
    return int'(k[31:0] & (ENTRIES - 1));
  endfunction

  function automatic entry_t read_slot(int idx);
    entry_t e;
    e = '0;
    if (slot_store.exists(idx)) e = slot_store[idx];
    return e;
  endfunction

  // mate scores move away from zero by ply, then saturate
  function automatic void write_slot(logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                                     logic [KIND_W-1:0] kind,
                                     logic signed [SCORE_W-1:0] sc,
                                     logic [MOVE_W-1:0] mv, logic [PLY_W-1:0] p);
    entry_t e;
    int s;
    s = int'(sc);
    if (s > MATE) s = s + int'(p);
    if (s < -MATE) s = s - int'(p);
    if (s > TOP_CAP) s = TOP_CAP;
    if (s < BOT_CAP) s = BOT_CAP;
    e.key   = k;
    e.depth = d;
    e.kind  = kind;
    e.score = SCORE_W'(s);
    e.move  = mv;
    slot_store[slot_index(k)] = e;
  endfunction

  // full key match gives the move; deep enough entry may also give a score
  function automatic probe_answer_t answer_probe(logic [KEY_W-1:0] k,
                                                 logic [DEPTH_W-1:0] d,
                                                 logic signed [SCORE_W-1:0] a,
                                                 logic signed [SCORE_W-1:0] b,
                                                 logic [PLY_W-1:0] p);
    entry_t e;
    probe_answer_t r;
    int s;
    e = read_slot(slot_index(k));
    r = '0;
    if (e.key == k) begin
      r.matched = 1'b1;
      r.move    = e.move;
      if (e.depth >= d) begin
        s = int'($signed(e.score));
        if (s > MATE) s = s - int'(p);
        if (s < -MATE) s = s + int'(p);
        case (e.kind)
          BOUND_EXACT: begin
            r.scored = 1'b1;
            r.value  = SCORE_W'(s);
          end
          BOUND_UPPER: begin
            if (s <= int'(a)) begin
              r.scored = 1'b1;
              r.value  = a;
            end
          end
          BOUND_LOWER: begin
            if (s >= int'(b)) begin
              r.scored = 1'b1;
              r.value  = b;
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", name, exp_val, got_val);
    end
  endtask

  // result side first, so a probe taken at this edge cannot pair with it
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word with no probe waiting");
        end else begin
          want = answers_due.pop_front();
          check_field("key_matched", longint'(want.matched), longint'(key_matched));
          check_field("hint_move", longint'(want.move), longint'(hint_move));
          check_field("score_valid", longint'(want.scored), longint'(score_valid));
          check_field("answer_score", longint'($signed(want.value)),
                      longint'(answer_score));
        end
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_STORE)
          write_slot(key, depth, bound_kind, score, move_in, ply);
        else
          answers_due.push_back(answer_probe(key, depth, alpha, beta, ply));
      end
    end
    pending <= answers_due.size();
  end

endmodule

// ===== dv/transposition_table_probe_store_tb.sv =====
`timescale 1ns / 1ps
// stimulus, handshake pacing and verdict for the transposition table
module transposition_table_probe_store_tb;
  import ttps_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 400;
  localparam int POOL        = 48;
  localparam int SLOT_GROUPS = 12;
  localparam int IDX_W       = $clog2(ENTRIES_DEFAULT);

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      operation;
  logic        [KEY_W-1:0]   key;
  logic        [DEPTH_W-1:0] depth;
  logic signed [SCORE_W-1:0] alpha;
  logic signed [SCORE_W-1:0] beta;
  logic        [KIND_W-1:0]  bound_kind;
  logic signed [SCORE_W-1:0] score;
  logic        [MOVE_W-1:0]  move_in;
  logic        [PLY_W-1:0]   ply;
  logic                      out_valid;
  logic                      out_stall;
  logic                      key_matched;
  logic        [MOVE_W-1:0]  hint_move;
  logic                      score_valid;
  logic signed [SCORE_W-1:0] answer_score;

  int mismatches;
  int pending;
  int cycle_count;
  int phase;

  logic [KEY_W-1:0] key_pool [POOL];
  logic [IDX_W-1:0] slot_base [SLOT_GROUPS];

  transposition_table_probe_store u_top (.*);

  transposition_table_probe_store_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic int sender_idle_pct(int ph);
    case (ph)
      0:       return 14;
      1:       return 63;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(int ph);
    case (ph)
      0:       return 63;
      1:       return 14;
      default: return 0;
    endcase
  endfunction

  // extremes, mate band or anything in range
  function automatic logic signed [SCORE_W-1:0] pick_score();
    int v;
    case ($urandom_range(5))
      0:       v = $urandom_range(1) ? 60000 : -60000;
      1, 2:    v = $urandom_range(1) ? int'($urandom_range(60000, 48000))
                                     : -int'($urandom_range(60000, 48000));
      default: v = int'($urandom_range(120000)) - 60000;
    endcase
    return SCORE_W'(v);
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    return ($urandom_range(3) == 0) ? DEPTH_W'($urandom) : DEPTH_W'($urandom_range(15));
  endfunction

  // offer one word and hold it until taken
  task automatic send_word(logic op, logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                           logic signed [SCORE_W-1:0] a, logic signed [SCORE_W-1:0] b,
                           logic [KIND_W-1:0] kind, logic signed [SCORE_W-1:0] s,
                           logic [MOVE_W-1:0] mv, logic [PLY_W-1:0] p);
    in_valid   <= 1'b1;
    operation  <= op;
    key        <= k;
    depth      <= d;
    alpha      <= a;
    beta       <= b;
    bound_kind <= kind;
    score      <= s;
    move_in    <= mv;
    ply        <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // unused fields of a probe or a store carry noise
  task automatic probe(logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                       logic signed [SCORE_W-1:0] a, logic signed [SCORE_W-1:0] b,
                       logic [PLY_W-1:0] p);
    send_word(OP_PROBE, k, d, a, b, KIND_W'($urandom), pick_score(),
              MOVE_W'($urandom), p);
  endtask

  task automatic store(logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                       logic [KIND_W-1:0] kind, logic signed [SCORE_W-1:0] s,
                       logic [MOVE_W-1:0] mv, logic [PLY_W-1:0] p);
    send_word(OP_STORE, k, d, pick_score(), pick_score(), kind, s, mv, p);
  endtask

  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // mostly keys from a pool of colliding slots, so stores are probed back
  task automatic random_word();
    logic [KEY_W-1:0] k;
    if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL - 1)];
    else k = {$urandom, $urandom};
    if ($urandom_range(99) < 45)
      store(k, pick_depth(), KIND_W'($urandom), pick_score(), MOVE_W'($urandom),
            PLY_W'($urandom));
    else
      probe(k, pick_depth(), pick_score(), pick_score(), PLY_W'($urandom));
  endtask

  // receiver pacing, with one long hold-off at the start of the last phase
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (phase == 2 && !held) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        out_stall <= ($urandom_range(99) < receiver_idle_pct(phase));
      end
    end
  end

  initial begin
    rst        = 1'b1;
    phase      = 0;
    in_valid   = 1'b0;
    operation  = OP_PROBE;
    key        = '0;
    depth      = '0;
    alpha      = '0;
    beta       = '0;
    bound_kind = BOUND_NONE;
    score      = '0;
    move_in    = '0;
    ply        = '0;

    // key pool: groups share a slot, slot zero among them
    for (int g = 0; g < SLOT_GROUPS; g++) slot_base[g] = IDX_W'($urandom);
    slot_base[0] = '0;
    for (int i = 0; i < POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][IDX_W-1:0] = slot_base[i % SLOT_GROUPS];
    end
    key_pool[0] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // cleared slot answers key zero, foreign key misses
    probe(64'h0, 8'd0, -17'sd60000, 17'sd60000, 8'd0);
    probe(64'h8000_0000_0000_1234, 8'd0, 17'sd0, 17'sd0, 8'd0);
    // exact mate scores at the extremes, adjusted both ways
    store(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, BOUND_EXACT, 17'sd60000, 24'hFFFFFF, 8'd255);
    probe(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, -17'sd60000, 17'sd60000, 8'd0);
    probe(64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 17'sd0, 17'sd0, 8'd255);
    // same slot, different upper key bits
    probe(64'h0000_FFFF_FFFF_FFFF, 8'd0, 17'sd0, 17'sd0, 8'd0);
    store(64'h8000_0000_0000_1234, 8'd10, BOUND_EXACT, -17'sd60000, 24'h0, 8'd255);
    probe(64'h8000_0000_0000_1234, 8'd10, 17'sd0, 17'sd0, 8'd17);
    // upper bound: cutoff, no cutoff, shallow entry
    store(64'h0123_4567_89AB_0001, 8'd5, BOUND_UPPER, -17'sd100, 24'h123456, 8'd0);
    probe(64'h0123_4567_89AB_0001, 8'd5, -17'sd50, 17'sd0, 8'd0);
    probe(64'h0123_4567_89AB_0001, 8'd4, -17'sd200, 17'sd0, 8'd0);
    probe(64'h0123_4567_89AB_0001, 8'd6, 17'sd0, 17'sd0, 8'd0);
    // lower bound: cutoff and no cutoff
    store(64'h7654_3210_FEDC_0002, 8'd3, BOUND_LOWER, 17'sd300, 24'h00ABCD, 8'd0);
    probe(64'h7654_3210_FEDC_0002, 8'd3, 17'sd0, 17'sd200, 8'd0);
    probe(64'h7654_3210_FEDC_0002, 8'd0, 17'sd0, 17'sd400, 8'd0);
    // bound kind none never scores
    store(64'h5A5A_0000_0000_0003, 8'd255, BOUND_NONE, 17'sd500, 24'h000777, 8'd0);
    probe(64'h5A5A_0000_0000_0003, 8'd0, 17'sd30000, -17'sd30000, 8'd0);
    // mate threshold edges
    store(64'h0123_4567_89AB_0001, 8'd1, BOUND_EXACT, 17'sd48000, 24'h000001, 8'd100);
    probe(64'h0123_4567_89AB_0001, 8'd1, 17'sd0, 17'sd0, 8'd100);
    store(64'h7654_3210_FEDC_0002, 8'd1, BOUND_EXACT, -17'sd48001, 24'h800000, 8'd200);
    probe(64'h7654_3210_FEDC_0002, 8'd0, 17'sd0, 17'sd0, 8'd200);
    // overwrite of the cleared slot at key zero
    store(64'h0, 8'd7, BOUND_LOWER, 17'sd48001, 24'h0F0F0F, 8'd9);
    probe(64'h0, 8'd7, 17'sd0, -17'sd60000, 8'd9);
    store(64'h8000_0000_0000_1234, 8'd20, BOUND_UPPER, -17'sd48000, 24'h3C3C3C, 8'd255);
    probe(64'h8000_0000_0000_1234, 8'd20, 17'sd60000, 17'sd0, 8'd255);

    // random words in three pacing phases
    for (int ph = 0; ph < 3; ph++) begin
      phase = ph;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        sender_gap(sender_idle_pct(ph));
        random_word();
      end
    end
    in_valid <= 1'b0;

    // drain, then idle on to catch any stray word
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ttps_pkg.sv
rtl/ttps_ctrl.sv
rtl/ttps_datapath.sv
rtl/transposition_table_probe_store.sv
rtl/ttps_checker.sv
dv/transposition_table_probe_store_checker.sv
dv/transposition_table_probe_store_tb.sv
